// ===== design/windowed_mean_abs_difference_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed mean absolute difference block
// Clocked property checks; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MEAN_ABS_DIFFERENCE_TOP_DEFINES_SVH
`define WINDOWED_MEAN_ABS_DIFFERENCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked while reset is released
`define WMAD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("wmad assertion failed");
// property checked at every edge, reset included
`define WMAD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("wmad assertion failed");
`else
`define WMAD_ASSERT(label, clk, rst_n, prop)
`define WMAD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/wmad_pkg.sv =====
// ----------------------------------------------------------------------------
// wmad_pkg
// Constants, types and helpers shared by the mean absolute difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmad_pkg;

    // window length in samples
    localparam int WINDOW = 64;
    localparam int AXES   = 3;
    localparam int SLOTS  = WINDOW - 1;

    // field and state widths
    localparam int SAMP_W = 16;
    localparam int DIFF_W = SAMP_W + 1;
    localparam int QUO_W  = 16;
    localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W  = DIFF_W + PTR_W;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DIV_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int AXIS_W = $clog2(AXES);
    localparam int RAM_D  = AXES * SLOTS;
    localparam int RAM_AW = $clog2(RAM_D);
    localparam int DATA_W = AXES * SAMP_W;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [DIV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [QUO_W-1:0]   quotient;
    } t_div_rsp;

    // first ring address of an axis
    function automatic logic [RAM_AW-1:0] ring_base(input logic [AXIS_W-1:0] axis);
        logic [RAM_AW-1:0] base;
        case (axis)
            AXIS_W'(1): base = RAM_AW'(SLOTS);
            AXIS_W'(2): base = RAM_AW'(2 * SLOTS);
            default:    base = '0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== design/wmad_div.sv =====
// ----------------------------------------------------------------------------
// wmad_div
// Restoring serial divider, one quotient bit per cycle, shared by all axes.
// ----------------------------------------------------------------------------
`default_nettype none

module wmad_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire wmad_pkg::t_div_req   i_req,
    output wmad_pkg::t_div_rsp        o_rsp
);
    import wmad_pkg::*;

    localparam int REM_W = DIV_W + 1;
    localparam int STP_W = $clog2(QUO_W + 1);

    logic [REM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;
    logic [STP_W-1:0] r_step;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] trial;
    logic             fits;

    // one trial subtraction per cycle
    assign trial = {r_rem[REM_W-2:0], r_quo[QUO_W-1]};
    assign fits  = (trial >= REM_W'(r_dvs));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STP_W'(QUO_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: the quotient fits in QUO_W bits, so the high dividend
    // bits start out below the divisor
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= REM_W'(i_req.dividend >> QUO_W);
            r_quo <= i_req.dividend[QUO_W-1:0];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - REM_W'(r_dvs)) : trial;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/windowed_mean_abs_difference_top.sv =====
// ----------------------------------------------------------------------------
// windowed_mean_abs_difference_top
// Per-axis mean absolute successive difference over a sliding sample window.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one request per three-axis sample (signed 16-bit X,
//   Y, Z). Master channel returns one result per request: the truncated mean
//   of |x[n]-x[n-1]| over the window for each axis, zero for the first
//   sample after reset.
//   A first sample goes from the idle state straight to the output state.
//   Every later sample passes, per axis in turn, through one ring read, one
//   sum update and a division in the shared serial divider, which produces
//   one quotient bit per cycle and is the unit that sets the rate.
//   o_s_axis_tready is high only while no sample is in work. A finished
//   result sits in the output register, and the next request is taken while
//   it waits; if the receiver still stalls when that next result is ready,
//   the block holds it and takes no further request.
//   Reset (synchronous, active low) empties the window and drops any pending
//   result. The difference ring needs no clearing pass; entries are only
//   read after the window has filled them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_mean_abs_difference_top_defines.svh"

module windowed_mean_abs_difference_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // sample_x [15:0], sample_y [31:16], sample_z [47:32]
    input  wire  [wmad_pkg::DATA_W-1:0]  i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    // mean_diff_x [15:0], mean_diff_y [31:16], mean_diff_z [47:32]
    output logic [wmad_pkg::DATA_W-1:0]  o_m_axis_tdata
);
    import wmad_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]              r_state;
    logic [AXIS_W-1:0]       r_axis;
    logic [CNT_W-1:0]        r_held;
    logic [PTR_W-1:0]        r_ptr;
    logic                    r_full;
    logic [DIV_W-1:0]        r_dvs;
    logic [SAMP_W-1:0]       r_samp [AXES];
    logic [SAMP_W-1:0]       r_last [AXES];
    logic [SUM_W-1:0]        r_sum  [AXES];
    logic [QUO_W-1:0]        r_res  [AXES];
    logic [DIFF_W-1:0]       r_mag;
    logic [DIFF_W-1:0]       r_rdata;
    logic [DIFF_W-1:0]       ring   [RAM_D];
    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_out_data;

    logic                    in_fire;
    logic                    out_fire;
    logic [RAM_AW-1:0]       ring_addr;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]       mag;
    logic [SUM_W-1:0]        n_sum;
    logic                    last_axis;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire  = r_out_valid && i_m_axis_tready;
    assign last_axis = (r_axis == AXIS_W'(AXES - 1));
    assign ring_addr = ring_base(r_axis) + RAM_AW'(r_ptr);

    // absolute difference of the current axis
    assign diff = $signed({r_samp[r_axis][SAMP_W-1], r_samp[r_axis]})
                - $signed({r_last[r_axis][SAMP_W-1], r_last[r_axis]});
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // oldest difference leaves once the window is full
    assign n_sum = r_sum[r_axis] - (r_full ? SUM_W'(r_rdata) : '0) + SUM_W'(r_mag);

    // shared divider
    assign div_req.start    = (r_state == ST_UPDATE);
    assign div_req.dividend = n_sum;
    assign div_req.divisor  = r_dvs;

    wmad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // difference ring, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rdata <= ring[ring_addr];
        end
        if (r_state == ST_UPDATE) begin
            ring[ring_addr] <= r_mag;
        end
    end

    // sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
            r_held  <= '0;
            r_ptr   <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_last[a] <= '0;
                r_sum[a]  <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_axis <= '0;
                        r_full <= (r_held == CNT_W'(WINDOW));
                        r_dvs  <= (r_held == CNT_W'(WINDOW)) ? DIV_W'(SLOTS)
                                                             : DIV_W'(r_held);
                        for (int a = 0; a < AXES; a++) begin
                            r_samp[a] <= i_s_axis_tdata[a*SAMP_W +: SAMP_W];
                        end
                        if (r_held == '0) begin
                            for (int a = 0; a < AXES; a++) begin
                                r_last[a] <= i_s_axis_tdata[a*SAMP_W +: SAMP_W];
                                r_res[a]  <= '0;
                            end
                            r_held  <= CNT_W'(1);
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_mag   <= mag;
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    r_sum[r_axis]  <= n_sum;
                    r_last[r_axis] <= r_samp[r_axis];
                    r_state        <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (div_rsp.done) begin
                        r_res[r_axis] <= div_rsp.quotient;
                        if (last_axis) begin
                            if (!r_full) begin
                                r_held <= r_held + 1'b1;
                            end
                            r_ptr   <= (r_ptr == PTR_W'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_out_valid || i_m_axis_tready)) begin
            for (int a = 0; a < AXES; a++) begin
                r_out_data[a*QUO_W +: QUO_W] <= r_res[a];
            end
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `WMAD_ASSERT(a_held_range, i_clk, i_rst_n, r_held <= CNT_W'(WINDOW))
    `WMAD_ASSERT(a_ptr_range, i_clk, i_rst_n, r_ptr < PTR_W'(SLOTS))
    `WMAD_ASSERT(a_div_idle_on_start, i_clk, i_rst_n, div_req.start |-> !div_rsp.busy)
    `WMAD_ASSERT(a_done_in_divide, i_clk, i_rst_n, div_rsp.done |-> (r_state == ST_DIVIDE))
    `WMAD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_m_axis_tvalid && r_held == '0))

endmodule

`default_nettype wire
